// ----- src/wrg_pkg.sv -----
// ----------------------------------------------------------------------------
// wrg_pkg
// Shared types and constants of the water ripple grid step block.
// ----------------------------------------------------------------------------
`default_nettype none

package wrg_pkg;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int COORD_W  = 9;
    localparam int HEIGHT_W = 18;
    localparam int CHAN_W   = 8;
    localparam int DAMP_W   = 16;
    localparam int DROP_W   = 8;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_POKE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SWAP   = 2'd2;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_DAMPING = 1'b0;
    localparam logic REG_DROP    = 1'b1;
    localparam logic [DAMP_W-1:0] DAMPING_RESET = 16'd64225;
    localparam logic [DROP_W-1:0] DROP_RESET    = 8'd255;

    // Height limits, signed Q10.8
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 18'sd131071;
    localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = -18'sd131072;

    // Colour constants
    localparam logic [CHAN_W-1:0] BASE_RED   = 8'd50;
    localparam logic [CHAN_W-1:0] BASE_GREEN = 8'd100;
    localparam logic [CHAN_W-1:0] BASE_BLUE  = 8'd150;
    localparam logic [15:0]       RECIP_FIVE = 16'd52429;  // 2^18 / 5, rounded up

    typedef logic signed [HEIGHT_W-1:0] height_t;

    typedef struct packed {
        logic [DAMP_W-1:0] damping;
        logic [DROP_W-1:0] drop_height;
    } cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        height_t            height;
    } px_req_t;

    typedef struct packed {
        logic re;
        logic we;
    } mem_ctl_t;

endpackage

`default_nettype wire

// ----- src/wrg_if.sv -----
// ----------------------------------------------------------------------------
// wrg_if
// Command and pixel channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface wrg_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [wrg_pkg::KIND_W-1:0]  kind;
    logic [wrg_pkg::COORD_W-1:0] col;
    logic [wrg_pkg::COORD_W-1:0] row;
    logic                        splash;

    modport source (output valid, output kind, output col, output row, output splash,
                    input ready);
    modport sink   (input valid, input kind, input col, input row, input splash,
                    output ready);
endinterface

interface wrg_pix_if;
    logic                        valid;
    logic                        ready;
    logic [wrg_pkg::COORD_W-1:0] pixel_col;
    logic [wrg_pkg::COORD_W-1:0] pixel_row;
    logic [wrg_pkg::CHAN_W-1:0]  red;
    logic [wrg_pkg::CHAN_W-1:0]  green;
    logic [wrg_pkg::CHAN_W-1:0]  blue;

    modport source (output valid, output pixel_col, output pixel_row, output red,
                    output green, output blue, input ready);
    modport sink   (input valid, input pixel_col, input pixel_row, input red,
                    input green, input blue, output ready);
endinterface

`default_nettype wire

// ----- src/wrg_mem.sv -----
// ----------------------------------------------------------------------------
// wrg_mem
// Single-port synchronous height memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wrg_mem #(
    parameter int DEPTH  = 262144,
    parameter int ADDR_W = 18
) (
    input  wire logic                  clk,
    input  wire wrg_pkg::mem_ctl_t     ctl,
    input  wire logic [ADDR_W-1:0]     addr,
    input  wire wrg_pkg::height_t      wdata,
    output      wrg_pkg::height_t      rdata
);

    wrg_pkg::height_t mem [DEPTH];
    wrg_pkg::height_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            mem[addr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/wrg_apb.sv -----
// ----------------------------------------------------------------------------
// wrg_apb
// APB register file: damping factor and drop height.
// ----------------------------------------------------------------------------
`default_nettype none

module wrg_apb (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [wrg_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [wrg_pkg::APB_DATA_W-1:0]      pwdata,
    output      logic [wrg_pkg::APB_DATA_W-1:0]      prdata,
    output      logic                                pready,
    output      wrg_pkg::cfg_t                       cfg
);

    logic [wrg_pkg::DAMP_W-1:0] damping_reg;
    logic [wrg_pkg::DROP_W-1:0] drop_reg;
    logic                       wr_en;
    logic                       reg_sel;

    // Registers are word aligned; the byte offset bits are ignored
    assign reg_sel = paddr[2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // Write registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            damping_reg <= wrg_pkg::DAMPING_RESET;
            drop_reg    <= wrg_pkg::DROP_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                wrg_pkg::REG_DAMPING: damping_reg <= pwdata[wrg_pkg::DAMP_W-1:0];
                wrg_pkg::REG_DROP:    drop_reg    <= pwdata[wrg_pkg::DROP_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_sel)
            wrg_pkg::REG_DAMPING:
                prdata = wrg_pkg::APB_DATA_W'(damping_reg);
            wrg_pkg::REG_DROP:
                prdata = wrg_pkg::APB_DATA_W'(drop_reg);
            default:
                prdata = '0;
        endcase
    end

    assign cfg.damping     = damping_reg;
    assign cfg.drop_height = drop_reg;

endmodule

`default_nettype wire

// ----- src/wrg_shade.sv -----
// ----------------------------------------------------------------------------
// wrg_shade
// Output stage: turns a cell height into RGB and holds the pixel transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module wrg_shade (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              px_valid,
    input  wire wrg_pkg::px_req_t  px_req,
    output      logic              px_ready,
    wrg_pix_if.source              pix
);

    logic                           out_valid_reg;
    logic [wrg_pkg::COORD_W-1:0]    col_reg;
    logic [wrg_pkg::COORD_W-1:0]    row_reg;
    logic [wrg_pkg::CHAN_W-1:0]     red_reg;
    logic [wrg_pkg::CHAN_W-1:0]     green_reg;
    logic [wrg_pkg::CHAN_W-1:0]     blue_reg;

    logic                           neg;
    logic [wrg_pkg::HEIGHT_W-1:0]   mag;
    logic [9:0]                     q_blue;
    logic [9:0]                     q_red;
    logic [27:0]                    green_prod;
    logic [9:0]                     q_green;

    // Base plus or minus the truncated quotient, clamped to 0..255
    function automatic logic [wrg_pkg::CHAN_W-1:0] clamp_chan(
        input logic [wrg_pkg::CHAN_W-1:0] base,
        input logic [9:0]                 q,
        input logic                       minus
    );
        logic signed [11:0] v;
        logic [wrg_pkg::CHAN_W-1:0] res;
        v = minus ? $signed({4'b0, base}) - $signed({2'b0, q})
                  : $signed({4'b0, base}) + $signed({2'b0, q});
        if (v < 0)
            res = '0;
        else if (v > 12'sd255)
            res = 8'd255;
        else
            res = v[wrg_pkg::CHAN_W-1:0];
        return res;
    endfunction

    // Magnitude and quotients, truncation toward zero
    assign neg        = px_req.height[wrg_pkg::HEIGHT_W-1];
    assign mag        = neg ? wrg_pkg::HEIGHT_W'(-px_req.height)
                            : wrg_pkg::HEIGHT_W'(px_req.height);
    assign q_blue     = mag[17:8];
    assign q_red      = {1'b0, mag[17:9]};
    // floor(mag/320) = floor(floor(mag/64)/5)
    assign green_prod = mag[17:6] * wrg_pkg::RECIP_FIVE;
    assign q_green    = green_prod[27:18];

    assign px_ready = !out_valid_reg || pix.ready;

    // Hold the pixel until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (px_ready)
        begin
            out_valid_reg <= px_valid;
        end
    end

    // Load pixel payload
    always_ff @(posedge clk)
    begin
        if (px_ready && px_valid)
        begin
            col_reg   <= px_req.col;
            row_reg   <= px_req.row;
            red_reg   <= clamp_chan(wrg_pkg::BASE_RED, q_red, neg);
            green_reg <= clamp_chan(wrg_pkg::BASE_GREEN, q_green, neg);
            blue_reg  <= clamp_chan(wrg_pkg::BASE_BLUE, q_blue, neg);
        end
    end

    assign pix.valid     = out_valid_reg;
    assign pix.pixel_col = col_reg;
    assign pix.pixel_row = row_reg;
    assign pix.red       = red_reg;
    assign pix.green     = green_reg;
    assign pix.blue      = blue_reg;

endmodule

`default_nettype wire

// ----- src/wrg_ctrl.sv -----
// ----------------------------------------------------------------------------
// wrg_ctrl
// Sequencer: clears the grids, decodes items and runs the read-modify-write
// of a cell against the previous and current height banks.
// ----------------------------------------------------------------------------
`default_nettype none

module wrg_ctrl #(
    parameter int GRID_WIDTH  = 512,
    parameter int GRID_HEIGHT = 512,
    parameter int ADDR_W      = 18
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    wrg_cmd_if.sink                   cmd,
    input  wire wrg_pkg::cfg_t        cfg,
    output      wrg_pkg::mem_ctl_t    b0_ctl,
    output      logic [ADDR_W-1:0]    b0_addr,
    output      wrg_pkg::height_t     b0_wdata,
    input  wire wrg_pkg::height_t     b0_rdata,
    output      wrg_pkg::mem_ctl_t    b1_ctl,
    output      logic [ADDR_W-1:0]    b1_addr,
    output      wrg_pkg::height_t     b1_wdata,
    input  wire wrg_pkg::height_t     b1_rdata,
    output      logic                 px_valid,
    output      wrg_pkg::px_req_t     px_req,
    input  wire logic                 px_ready
);

    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(GRID_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_DISPATCH,
        S_POKE,
        S_RD,
        S_ACC,
        S_DIFF,
        S_MUL,
        S_RND,
        S_WB,
        S_BORD,
        S_EMIT
    } state_t;

    // Control registers
    state_t                      state_reg,  state_next;
    logic                        bank_reg,   bank_next;
    logic [ADDR_W-1:0]           clr_reg,    clr_next;
    logic [2:0]                  cnt_reg,    cnt_next;
    logic                        rd_vld_reg, rd_vld_next;

    // Item and datapath registers
    logic [wrg_pkg::KIND_W-1:0]  kind_reg;
    logic [wrg_pkg::COORD_W-1:0] col_reg;
    logic [wrg_pkg::COORD_W-1:0] row_reg;
    logic                        splash_reg;
    logic [ADDR_W-1:0]           addr_reg;
    logic                        in_grid_reg;
    logic                        inner_reg;
    logic                        deep_reg;
    logic signed [19:0]          acc_reg;
    logic signed [20:0]          t_reg;
    logic signed [37:0]          p_reg;
    logic [20:0]                 mag_reg;
    logic                        neg_reg;
    wrg_pkg::height_t            h_reg;

    // Combinational helpers
    logic                        in_grid_c;
    logic                        inner_c;
    logic                        deep_c;
    logic [ADDR_W-1:0]           addr_c;
    logic [37:0]                 p_abs;
    wrg_pkg::height_t            h_sat;
    wrg_pkg::height_t            prev_rdata;
    wrg_pkg::height_t            cur_rdata;
    wrg_pkg::height_t            poke_h;

    wrg_pkg::mem_ctl_t           prev_ctl;
    logic [ADDR_W-1:0]           prev_addr;
    wrg_pkg::height_t            prev_wdata;
    wrg_pkg::mem_ctl_t           cur_ctl;
    logic [ADDR_W-1:0]           cur_addr;
    wrg_pkg::height_t            cur_wdata;

    // Neighbor of the centre cell, one of four directions
    function automatic logic [ADDR_W-1:0] nb_addr(
        input logic [ADDR_W-1:0] a,
        input logic [1:0]        dir
    );
        logic [ADDR_W-1:0] res;
        case (dir)
            2'd0:    res = a - ADDR_W'(1);
            2'd1:    res = a + ADDR_W'(1);
            2'd2:    res = a - ROW_STEP;
            default: res = a + ROW_STEP;
        endcase
        return res;
    endfunction

    // Cell position flags and linear address
    assign in_grid_c = (32'(col_reg) < GRID_WIDTH) && (32'(row_reg) < GRID_HEIGHT);
    assign inner_c   = (col_reg != '0) && (32'(col_reg) < GRID_WIDTH - 1) &&
                       (row_reg != '0) && (32'(row_reg) < GRID_HEIGHT - 1);
    assign deep_c    = (col_reg > 9'd1) && (32'(col_reg) < GRID_WIDTH - 2) &&
                       (row_reg > 9'd1) && (32'(row_reg) < GRID_HEIGHT - 2);
    assign addr_c    = ADDR_W'(32'(row_reg) * GRID_WIDTH + 32'(col_reg));

    // Round half away from zero and saturate
    assign p_abs = p_reg[37] ? 38'(-p_reg) : 38'(p_reg);
    always_comb
    begin
        if (neg_reg)
        begin
            if (mag_reg > 21'd131072)
                h_sat = wrg_pkg::HEIGHT_MIN;
            else
                h_sat = wrg_pkg::HEIGHT_W'(-$signed({1'b0, mag_reg}));
        end
        else
        begin
            if (mag_reg > 21'd131071)
                h_sat = wrg_pkg::HEIGHT_MAX;
            else
                h_sat = wrg_pkg::HEIGHT_W'(mag_reg);
        end
    end

    assign poke_h = {2'b00, cfg.drop_height, 8'h00};

    // Next state and memory port control
    always_comb
    begin
        state_next  = state_reg;
        bank_next   = bank_reg;
        clr_next    = clr_reg;
        cnt_next    = cnt_reg;
        rd_vld_next = 1'b0;
        cmd.ready   = 1'b0;
        px_valid    = 1'b0;
        prev_ctl    = '0;
        prev_addr   = addr_reg;
        prev_wdata  = poke_h;
        cur_ctl     = '0;
        cur_addr    = addr_reg;
        cur_wdata   = h_sat;

        case (state_reg)
            S_CLEAR:
            begin
                prev_ctl.we = 1'b1;
                cur_ctl.we  = 1'b1;
                prev_addr   = clr_reg;
                cur_addr    = clr_reg;
                prev_wdata  = '0;
                cur_wdata   = '0;
                clr_next    = clr_reg + ADDR_W'(1);
                if (clr_reg == LAST_ADDR)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                    state_next = S_ADDR;
            end
            S_ADDR:
            begin
                state_next = S_DISPATCH;
            end
            S_DISPATCH:
            begin
                case (kind_reg)
                    wrg_pkg::KIND_POKE:
                    begin
                        cnt_next   = '0;
                        state_next = inner_reg ? S_POKE : S_IDLE;
                    end
                    wrg_pkg::KIND_SWAP:
                    begin
                        bank_next  = !bank_reg;
                        state_next = S_IDLE;
                    end
                    wrg_pkg::KIND_UPDATE:
                    begin
                        if (!in_grid_reg)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            cur_ctl.re = 1'b1;
                            if (inner_reg)
                            begin
                                prev_ctl.re = 1'b1;
                                prev_addr   = nb_addr(addr_reg, 2'd0);
                                rd_vld_next = 1'b1;
                                cnt_next    = 3'd1;
                                state_next  = S_RD;
                            end
                            else
                            begin
                                state_next = S_BORD;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POKE:
            begin
                prev_ctl.we = 1'b1;
                if (cnt_reg != '0)
                    prev_addr = nb_addr(addr_reg, 2'(cnt_reg - 3'd1));
                cnt_next = cnt_reg + 3'd1;
                if ((cnt_reg == '0 && !(splash_reg && deep_reg)) || cnt_reg == 3'd4)
                    state_next = S_IDLE;
            end
            S_RD:
            begin
                prev_ctl.re = 1'b1;
                prev_addr   = nb_addr(addr_reg, cnt_reg[1:0]);
                rd_vld_next = 1'b1;
                cnt_next    = cnt_reg + 3'd1;
                if (cnt_reg == 3'd3)
                    state_next = S_ACC;
            end
            S_ACC:
            begin
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_RND;
            end
            S_RND:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                cur_ctl.we = 1'b1;
                state_next = S_EMIT;
            end
            S_BORD:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                px_valid = 1'b1;
                if (px_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Map previous/current roles onto the two banks
    assign prev_rdata = bank_reg ? b1_rdata : b0_rdata;
    assign cur_rdata  = bank_reg ? b0_rdata : b1_rdata;
    assign b0_ctl     = bank_reg ? cur_ctl   : prev_ctl;
    assign b0_addr    = bank_reg ? cur_addr  : prev_addr;
    assign b0_wdata   = bank_reg ? cur_wdata : prev_wdata;
    assign b1_ctl     = bank_reg ? prev_ctl   : cur_ctl;
    assign b1_addr    = bank_reg ? prev_addr  : cur_addr;
    assign b1_wdata   = bank_reg ? prev_wdata : cur_wdata;

    assign px_req.col    = col_reg;
    assign px_req.row    = row_reg;
    assign px_req.height = h_reg;

    // Hold state and control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            bank_reg   <= 1'b0;
            clr_reg    <= '0;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bank_reg   <= bank_next;
            clr_reg    <= clr_next;
            cnt_reg    <= cnt_next;
            rd_vld_reg <= rd_vld_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd.valid)
        begin
            kind_reg   <= cmd.kind;
            col_reg    <= cmd.col;
            row_reg    <= cmd.row;
            splash_reg <= cmd.splash;
        end
        if (state_reg == S_ADDR)
        begin
            addr_reg    <= addr_c;
            in_grid_reg <= in_grid_c;
            inner_reg   <= inner_c;
            deep_reg    <= deep_c;
        end
        // Sum neighbors as they return from the previous bank
        if (state_reg == S_DISPATCH)
            acc_reg <= '0;
        else if (rd_vld_reg)
            acc_reg <= acc_reg + 20'(prev_rdata);
        if (state_reg == S_DIFF)
            t_reg <= 21'(acc_reg) - (21'(cur_rdata) <<< 1);
        if (state_reg == S_MUL)
            p_reg <= 38'(t_reg) * 38'($signed({1'b0, cfg.damping}));
        if (state_reg == S_RND)
        begin
            neg_reg <= p_reg[37];
            mag_reg <= 21'((p_abs + 38'd65536) >> 17);
        end
        if (state_reg == S_DISPATCH)
            h_reg <= '0;
        else if (state_reg == S_BORD)
            h_reg <= cur_rdata;
        else if (state_reg == S_WB)
            h_reg <= h_sat;
    end

    // A bank takes a read or a write in a cycle, never both
    a_bank_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(b0_ctl.re && b0_ctl.we) && !(b1_ctl.re && b1_ctl.we))
        else $error("bank read and write in the same cycle");

    // Bank roles change only on a swap item
    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |->
            $past(state_reg == S_DISPATCH && kind_reg == wrg_pkg::KIND_SWAP))
        else $error("bank select changed outside a swap");

    // Only update items produce a pixel
    a_px_kind: assert property (@(posedge clk) disable iff (!rst_n)
        px_valid |-> (kind_reg == wrg_pkg::KIND_UPDATE))
        else $error("pixel issued for a non-update item");

    // The current bank is written back only at the cell it was read from
    a_wb_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_ctl.we && state_reg != S_CLEAR) |-> (cur_addr == addr_reg && inner_reg))
        else $error("current bank written at a foreign address");

endmodule

`default_nettype wire

// ----- src/water_ripple_grid_step.sv -----
// ----------------------------------------------------------------------------
// water_ripple_grid_step
// Two-bank water ripple height grid with poke, update/render and swap items.
//
// Items arrive on cmd (valid/ready): kind poke writes the drop height into an
// interior cell of the previous grid (with splash, also its four neighbors if
// they are interior too), kind update recomputes one interior cell of the
// current grid and returns its colour on pix, kind swap exchanges the two
// grids. damping and drop_height are set over APB.
// One item is worked at a time. Swap, an unused kind and a poke outside the
// interior end after decode; other pokes then write the cell and, with
// splash, its neighbors. An update outside the grid goes to the pixel step
// with height zero, a border cell first reads the current grid, and an
// interior cell adds the four neighbor reads through the single port of the
// previous bank plus the subtract, multiply, round and write-back steps. A
// new item is taken while the pixel waits in the output register. If pix
// stalls, a second update holds in its last step until the register frees.
// After reset both banks are cleared one address per cycle; cmd.ready stays
// low until then, while the APB registers accept writes at once.
// ----------------------------------------------------------------------------
`default_nettype none

module water_ripple_grid_step #(
    parameter int GRID_WIDTH  = 512,
    parameter int GRID_HEIGHT = 512
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    wrg_cmd_if.sink                              cmd,
    wrg_pix_if.source                            pix,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wrg_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [wrg_pkg::APB_DATA_W-1:0]  pwdata,
    output      logic [wrg_pkg::APB_DATA_W-1:0]  prdata,
    output      logic                            pready
);

    localparam int DEPTH  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    wrg_pkg::cfg_t      cfg;
    wrg_pkg::mem_ctl_t  b0_ctl;
    wrg_pkg::mem_ctl_t  b1_ctl;
    logic [ADDR_W-1:0]  b0_addr;
    logic [ADDR_W-1:0]  b1_addr;
    wrg_pkg::height_t   b0_wdata;
    wrg_pkg::height_t   b1_wdata;
    wrg_pkg::height_t   b0_rdata;
    wrg_pkg::height_t   b1_rdata;
    logic               px_valid;
    logic               px_ready;
    wrg_pkg::px_req_t   px_req;

    // Configuration registers
    wrg_apb u_apb (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Height banks
    wrg_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_bank0 (
        .clk   (clk),
        .ctl   (b0_ctl),
        .addr  (b0_addr),
        .wdata (b0_wdata),
        .rdata (b0_rdata)
    );

    wrg_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_bank1 (
        .clk   (clk),
        .ctl   (b1_ctl),
        .addr  (b1_addr),
        .wdata (b1_wdata),
        .rdata (b1_rdata)
    );

    // Item sequencer
    wrg_ctrl #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .b0_ctl   (b0_ctl),
        .b0_addr  (b0_addr),
        .b0_wdata (b0_wdata),
        .b0_rdata (b0_rdata),
        .b1_ctl   (b1_ctl),
        .b1_addr  (b1_addr),
        .b1_wdata (b1_wdata),
        .b1_rdata (b1_rdata),
        .px_valid (px_valid),
        .px_req   (px_req),
        .px_ready (px_ready)
    );

    // Colour and output register
    wrg_shade u_shade (
        .clk      (clk),
        .rst_n    (rst_n),
        .px_valid (px_valid),
        .px_req   (px_req),
        .px_ready (px_ready),
        .pix      (pix)
    );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the water ripple grid step block. A local model of
// both height banks, the bank select and the two registers predicts the
// colour of every update transaction; each pixel leaving the block is compared
// field by field with the oldest prediction. Directed border, splash and
// saturation cases come first, then a back-pressure run, then random phases
// under several damping and drop settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID_W     = 512;
    localparam int GRID_H     = 512;
    localparam int GRID_CELLS = GRID_W * GRID_H;
    localparam int CLK_HALF   = 2;
    // Let a trailing item finish; leave margin before APB writes
    localparam int SETTLE_CYCLES = 16;
    localparam int SWEEP_SIZE    = 6;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [wrg_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [wrg_pkg::APB_ADDR_W-1:0] ADDR_DAMPING = {wrg_pkg::REG_DAMPING, 2'b00};
    localparam logic [wrg_pkg::APB_ADDR_W-1:0] ADDR_DROP    = {wrg_pkg::REG_DROP, 2'b00};

    typedef struct {
        logic [wrg_pkg::COORD_W-1:0] col;
        logic [wrg_pkg::COORD_W-1:0] row;
        logic [wrg_pkg::CHAN_W-1:0]  red;
        logic [wrg_pkg::CHAN_W-1:0]  green;
        logic [wrg_pkg::CHAN_W-1:0]  blue;
    } pixel_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [wrg_pkg::APB_ADDR_W-1:0] paddr;
    logic [wrg_pkg::APB_DATA_W-1:0] pwdata;
    logic [wrg_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    wrg_cmd_if cmd_ch ();
    wrg_pix_if pix_ch ();

    // Local copy of the block state
    wrg_pkg::height_t           height_grid [2][GRID_CELLS];
    logic                       bank_sel;
    logic [wrg_pkg::DAMP_W-1:0] damping_cfg;
    logic [wrg_pkg::DROP_W-1:0] drop_cfg;

    pixel_t pending_pixels [$];
    int     mismatch_count = 0;
    bit     steady = 1'b0;
    int     pix_hold_cycles = 0;

    water_ripple_grid_step #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .pix     (pix_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #CLK_HALF clk = ~clk;

    // Abort a hung run, allowing for the grid clear after reset
    initial
    begin
        #6_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic bit is_interior(logic [wrg_pkg::COORD_W-1:0] col,
                                       logic [wrg_pkg::COORD_W-1:0] row);
        return col > 0 && col < GRID_W - 1 && row > 0 && row < GRID_H - 1;
    endfunction

    function automatic logic [wrg_pkg::CHAN_W-1:0] clamp_chan(int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return 8'd255;
        return v[wrg_pkg::CHAN_W-1:0];
    endfunction

    function automatic void ripple_step(logic [wrg_pkg::KIND_W-1:0] kind,
                                        logic [wrg_pkg::COORD_W-1:0] col,
                                        logic [wrg_pkg::COORD_W-1:0] row, logic splash);
        wrg_pkg::height_t drop_h;
        int      addr;
        int      hv;
        longint  acc;
        longint  prod;
        longint  mag;
        logic    cur_bank;
        pixel_t  px;
        drop_h   = $signed({2'b00, drop_cfg, 8'h00});
        cur_bank = ~bank_sel;
        addr     = int'(row) * GRID_W + int'(col);
        case (kind)
            wrg_pkg::KIND_POKE:
            begin
                if (is_interior(col, row))
                begin
                    height_grid[bank_sel][addr] = drop_h;
                    // Splash only where all four neighbors are interior too
                    if (splash && col > 1 && col < GRID_W - 2 && row > 1 && row < GRID_H - 2)
                    begin
                        height_grid[bank_sel][addr + 1]      = drop_h;
                        height_grid[bank_sel][addr - 1]      = drop_h;
                        height_grid[bank_sel][addr + GRID_W] = drop_h;
                        height_grid[bank_sel][addr - GRID_W] = drop_h;
                    end
                end
            end
            wrg_pkg::KIND_SWAP:
                bank_sel = ~bank_sel;
            wrg_pkg::KIND_UPDATE:
            begin
                if (is_interior(col, row))
                begin
                    acc = longint'(height_grid[bank_sel][addr - 1])
                        + longint'(height_grid[bank_sel][addr + 1])
                        + longint'(height_grid[bank_sel][addr - GRID_W])
                        + longint'(height_grid[bank_sel][addr + GRID_W])
                        - 2 * longint'(height_grid[cur_bank][addr]);
                    prod = acc * longint'(damping_cfg);
                    // Round Q.25 to Q.8, ties away from zero, then saturate
                    mag = ((prod < 0 ? -prod : prod) + 65536) >>> 17;
                    if (prod < 0)
                        mag = -mag;
                    if (mag > longint'(wrg_pkg::HEIGHT_MAX))
                        mag = longint'(wrg_pkg::HEIGHT_MAX);
                    if (mag < longint'(wrg_pkg::HEIGHT_MIN))
                        mag = longint'(wrg_pkg::HEIGHT_MIN);
                    height_grid[cur_bank][addr] = wrg_pkg::height_t'(mag);
                end
                hv       = int'(height_grid[cur_bank][addr]);
                px.col   = col;
                px.row   = row;
                px.red   = clamp_chan(int'(wrg_pkg::BASE_RED) + hv / 512);
                px.green = clamp_chan(int'(wrg_pkg::BASE_GREEN) + hv / 320);
                px.blue  = clamp_chan(int'(wrg_pkg::BASE_BLUE) + hv / 256);
                pending_pixels.push_back(px);
            end
            default:
                ; // unused kind: dropped by the block
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t pixel %s: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Check outgoing pixels, then predict from the incoming transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_ch.valid && pix_ch.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t pixel with none pending: expected nothing, actual (%0d,%0d)",
                             $time, pix_ch.pixel_col, pix_ch.pixel_row);
                    mismatch_count++;
                end
                else
                begin
                    pixel_t want;
                    want = pending_pixels.pop_front();
                    check_field("col", want.col, pix_ch.pixel_col);
                    check_field("row", want.row, pix_ch.pixel_row);
                    check_field("red", want.red, pix_ch.red);
                    check_field("green", want.green, pix_ch.green);
                    check_field("blue", want.blue, pix_ch.blue);
                end
            end
            if (cmd_ch.valid && cmd_ch.ready)
                ripple_step(cmd_ch.kind, cmd_ch.col, cmd_ch.row, cmd_ch.splash);
        end
    end

    // ------------------------------------------------------------------------
    // Idling and pixel receiver
    // ------------------------------------------------------------------------
    function automatic int pick_gap(int min_len);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return min_len;
        if (r < 95)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    // Drop ready at random, or for a long hold when a test asks for one
    initial
    begin
        pix_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pix_hold_cycles > 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (pix_hold_cycles) @(posedge clk);
                pix_hold_cycles = 0;
                pix_ch.ready <= 1'b1;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                pix_ch.ready <= 1'b0;
                repeat (pick_gap(1)) @(posedge clk);
                pix_ch.ready <= 1'b1;
            end
            else
                pix_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [wrg_pkg::KIND_W-1:0] kind,
                             input logic [wrg_pkg::COORD_W-1:0] col,
                             input logic [wrg_pkg::COORD_W-1:0] row, input logic splash);
        int gap;
        cmd_ch.valid  <= 1'b1;
        cmd_ch.kind   <= kind;
        cmd_ch.col    <= col;
        cmd_ch.row    <= row;
        cmd_ch.splash <= splash;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        gap = steady ? 0 : pick_gap(0);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Setup cycle, access cycle, then idle between transactions
    task automatic write_reg(input logic idx, input logic [wrg_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (idx == wrg_pkg::REG_DAMPING) ? ADDR_DAMPING : ADDR_DROP;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == wrg_pkg::REG_DAMPING)
            damping_cfg = value[wrg_pkg::DAMP_W-1:0];
        else
            drop_cfg = value[wrg_pkg::DROP_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Set both registers; upper data bits carry noise the block must ignore
    task automatic set_config(input logic [wrg_pkg::DAMP_W-1:0] damping,
                              input logic [wrg_pkg::DROP_W-1:0] drop);
        write_reg(wrg_pkg::REG_DAMPING, {16'($urandom), damping});
        write_reg(wrg_pkg::REG_DROP, {24'($urandom), drop});
    endtask

    // Drain all pending pixels and let a trailing poke finish
    task automatic wait_idle();
        cmd_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [wrg_pkg::COORD_W-1:0] any_coord();
        logic [wrg_pkg::COORD_W-1:0] picks [6] = '{
            wrg_pkg::COORD_W'(0), wrg_pkg::COORD_W'(1), wrg_pkg::COORD_W'(2),
            wrg_pkg::COORD_W'(GRID_W - 3), wrg_pkg::COORD_W'(GRID_W - 2),
            wrg_pkg::COORD_W'(GRID_W - 1)};
        if ($urandom_range(0, 2) == 0)
            return picks[$urandom_range(0, 5)];
        return wrg_pkg::COORD_W'($urandom_range(0, GRID_W - 1));
    endfunction

    // One frame over a small window: update every cell, then swap banks
    task automatic sweep_window(input int c0, input int r0);
        for (int r = r0; r < r0 + SWEEP_SIZE; r++)
            for (int c = c0; c < c0 + SWEEP_SIZE; c++)
                send_item(wrg_pkg::KIND_UPDATE, wrg_pkg::COORD_W'(c), wrg_pkg::COORD_W'(r),
                          1'($urandom_range(0, 1)));
        send_item(wrg_pkg::KIND_SWAP, any_coord(), any_coord(), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Borders, splash limits, unused kind and bank swap at reset settings
    task automatic test_edges_and_specials();
        logic [wrg_pkg::COORD_W-1:0] c_last;
        logic [wrg_pkg::COORD_W-1:0] c_m2;
        logic [wrg_pkg::COORD_W-1:0] c_m3;
        logic [wrg_pkg::COORD_W-1:0] r_last;
        logic [wrg_pkg::COORD_W-1:0] r_m2;
        logic [wrg_pkg::COORD_W-1:0] r_m3;
        c_last = wrg_pkg::COORD_W'(GRID_W - 1);
        c_m2   = wrg_pkg::COORD_W'(GRID_W - 2);
        c_m3   = wrg_pkg::COORD_W'(GRID_W - 3);
        r_last = wrg_pkg::COORD_W'(GRID_H - 1);
        r_m2   = wrg_pkg::COORD_W'(GRID_H - 2);
        r_m3   = wrg_pkg::COORD_W'(GRID_H - 3);
        send_item(wrg_pkg::KIND_UPDATE, 0, 0, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, c_last, r_last, 1'b1);
        send_item(wrg_pkg::KIND_POKE, 0, 200, 1'b1);
        send_item(wrg_pkg::KIND_POKE, c_last, 200, 1'b1);
        send_item(wrg_pkg::KIND_POKE, 200, 0, 1'b1);
        send_item(wrg_pkg::KIND_POKE, 200, r_last, 1'b1);
        send_item(wrg_pkg::KIND_POKE, 1, 1, 1'b1);
        send_item(wrg_pkg::KIND_POKE, c_m2, r_m2, 1'b1);
        send_item(wrg_pkg::KIND_POKE, 2, 2, 1'b1);
        send_item(wrg_pkg::KIND_POKE, c_m3, r_m3, 1'b1);
        send_item(KIND_UNUSED, c_last, r_last, 1'b1);
        send_item(wrg_pkg::KIND_UPDATE, 1, 1, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, 2, 2, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, c_m2, r_m2, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, c_m3, r_m3, 1'b0);
        send_item(wrg_pkg::KIND_SWAP, c_last, r_last, 1'b1);
        send_item(wrg_pkg::KIND_UPDATE, 2, 2, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, c_m2, r_m2, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, 0, 300, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, 300, r_last, 1'b0);
        send_item(wrg_pkg::KIND_SWAP, 0, 0, 1'b0);
        send_item(wrg_pkg::KIND_POKE, 256, 256, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, 256, 256, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, 255, 256, 1'b0);
    endtask

    // Drive a cell to a large negative height, then past the positive limit
    task automatic test_saturation();
        wait_idle();
        set_config(16'hFFFF, 8'hFF);
        send_item(wrg_pkg::KIND_POKE, 300, 300, 1'b0);
        send_item(wrg_pkg::KIND_SWAP, 0, 0, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, 300, 300, 1'b0);
        send_item(wrg_pkg::KIND_POKE, 300, 300, 1'b1);
        send_item(wrg_pkg::KIND_UPDATE, 300, 300, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, 301, 300, 1'b0);
        send_item(wrg_pkg::KIND_SWAP, 0, 0, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, 300, 300, 1'b0);
        send_item(wrg_pkg::KIND_UPDATE, 301, 300, 1'b0);
    endtask

    // Hold the pixel side off while updates keep coming, so cmd stalls
    task automatic test_backpressure();
        wait_idle();
        steady = 1'b1;
        pix_hold_cycles = HOLD_CYCLES;
        send_item(wrg_pkg::KIND_POKE, 100, 100, 1'b1);
        for (int i = 0; i < 40; i++)
            send_item(wrg_pkg::KIND_UPDATE, wrg_pkg::COORD_W'(98 + i % 5),
                      wrg_pkg::COORD_W'(98 + i / 8), 1'b0);
        wait_idle();
        steady = 1'b0;
    endtask

    // Mostly local activity around a window, some anywhere in the grid
    task automatic random_phase(input int n_items);
        int                          sent;
        int                          pick;
        int                          wc;
        int                          wr;
        logic [wrg_pkg::KIND_W-1:0]  kind;
        logic [wrg_pkg::COORD_W-1:0] col;
        logic [wrg_pkg::COORD_W-1:0] row;
        sent = 0;
        wc   = $urandom_range(1, GRID_W - 12);
        wr   = $urandom_range(1, GRID_H - 12);
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                sweep_window(wc, wr);
                sent += SWEEP_SIZE * SWEEP_SIZE + 1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    kind = wrg_pkg::KIND_POKE;
                else if (pick < 85)
                    kind = wrg_pkg::KIND_UPDATE;
                else if (pick < 95)
                    kind = wrg_pkg::KIND_SWAP;
                else
                    kind = KIND_UNUSED;
                if ($urandom_range(0, 3) != 0)
                begin
                    col = wrg_pkg::COORD_W'(wc + $urandom_range(0, 7));
                    row = wrg_pkg::COORD_W'(wr + $urandom_range(0, 7));
                end
                else
                begin
                    col = any_coord();
                    row = any_coord();
                end
                send_item(kind, col, row, 1'($urandom_range(0, 1)));
                if (kind != KIND_UNUSED)
                    sent++;
            end
        end
    endtask

    // Random traffic under the register extremes, the reset damping and random settings
    task automatic test_random_settings();
        wait_idle();
        set_config(16'hFFFF, 8'hFF);
        random_phase(300);
        wait_idle();
        steady = 1'b1;
        set_config(16'h0000, 8'h00);
        random_phase(200);
        wait_idle();
        steady = 1'b0;
        set_config(wrg_pkg::DAMP_W'($urandom_range(0, 65535)),
                   wrg_pkg::DROP_W'($urandom_range(0, 255)));
        random_phase(300);
        wait_idle();
        set_config(wrg_pkg::DAMPING_RESET, 8'd1);
        random_phase(150);
        wait_idle();
        set_config(wrg_pkg::DAMP_W'($urandom_range(32768, 65535)),
                   wrg_pkg::DROP_W'($urandom_range(128, 255)));
        random_phase(200);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        for (int b = 0; b < 2; b++)
            for (int a = 0; a < GRID_CELLS; a++)
                height_grid[b][a] = '0;
        bank_sel      = 1'b0;
        damping_cfg   = wrg_pkg::DAMPING_RESET;
        drop_cfg      = wrg_pkg::DROP_RESET;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cmd_ch.valid  = 1'b0;
        cmd_ch.kind   = wrg_pkg::KIND_POKE;
        cmd_ch.col    = '0;
        cmd_ch.row    = '0;
        cmd_ch.splash = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_edges_and_specials();
        test_saturation();
        test_backpressure();
        test_random_settings();
        wait_idle();

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
